// ===== hw/rtl/kplc_pkg.sv =====
// Shared types and constants for the keypad PIN lock controller.
// Used by kplc_cfg_regs, kplc_core and keypad_pin_lock_controller_top.
package kplc_pkg;

    localparam logic [7:0] KEY_SUBMIT = 8'h44;
    localparam logic [7:0] KEY_BACK   = 8'h2A;
    localparam logic [5:0] SECS_PER_MIN = 6'd60;
    localparam logic [3:0] CNT_MAX = 4'hF;
    localparam logic [15:0] MIN_MAX = 16'hFFFF;

    localparam logic [7:0] CFG_ATTEMPTS = 8'd0;
    localparam logic [7:0] CFG_LOCKOUTS = 8'd1;
    localparam logic [7:0] CFG_STEP     = 8'd2;
    localparam logic [7:0] CFG_UNLOCK   = 8'd3;

    localparam logic [3:0] ST_ENTERING = 4'd0;
    localparam logic [3:0] ST_DIGIT    = 4'd1;
    localparam logic [3:0] ST_GRANTED  = 4'd2;
    localparam logic [3:0] ST_WRONG    = 4'd3;
    localparam logic [3:0] ST_LOCKOUT  = 4'd4;
    localparam logic [3:0] ST_COUNTING = 4'd5;
    localparam logic [3:0] ST_LOCKDOWN = 4'd6;
    localparam logic [3:0] ST_NEWPIN   = 4'd7;
    localparam logic [3:0] ST_STORED   = 4'd8;
    localparam logic [3:0] ST_IGNORED  = 4'd9;

    typedef struct packed {
        logic [3:0] attempts_before_lockout;
        logic [3:0] lockouts_before_lockdown;
        logic [7:0] lockout_step_seconds;
        logic [7:0] unlock_seconds;
    } t_cfg;

    typedef struct packed {
        logic       reset_switch;
        logic [7:0] key_code;
        logic       cmd;
    } t_in_item;

    typedef struct packed {
        logic [15:0] minutes_value;
        logic [11:0] seconds_value;
        logic [4:0]  digits_entered;
        logic        alarm;
        logic        door_open;
        logic [3:0]  status;
    } t_result;

endpackage

// ===== hw/rtl/kplc_cfg_regs.sv =====
// Configuration register bank for the keypad PIN lock controller.
// Depends on kplc_pkg for the register indexes and the t_cfg struct.
module kplc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output kplc_pkg::t_cfg o_cfg
);
    import kplc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attempts_before_lockout  <= 4'd3;
            r_cfg.lockouts_before_lockdown <= 4'd3;
            r_cfg.lockout_step_seconds     <= 8'd10;
            r_cfg.unlock_seconds           <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTEMPTS: r_cfg.attempts_before_lockout  <= i_cfg_data[3:0];
                CFG_LOCKOUTS: r_cfg.lockouts_before_lockdown <= i_cfg_data[3:0];
                CFG_STEP:     r_cfg.lockout_step_seconds     <= i_cfg_data;
                CFG_UNLOCK:   r_cfg.unlock_seconds           <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/kplc_core.sv =====
// Lock state, entry buffer, stored PIN and counters with their next-state logic.
// Depends on kplc_pkg; state advances once per item when i_advance is high.
module kplc_core #(
    parameter int PIN_LEN = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  kplc_pkg::t_in_item i_item,
    input  kplc_pkg::t_cfg    i_cfg,
    output kplc_pkg::t_result o_result
);
    import kplc_pkg::*;

    localparam int PW = $clog2(PIN_LEN + 1);
    localparam int IW = (PIN_LEN > 1) ? $clog2(PIN_LEN) : 1;
    localparam logic [PW-1:0] POS_FULL = PW'(PIN_LEN);

    typedef enum logic [2:0] {
        MD_ENTER, MD_OPEN, MD_WAITD, MD_LOCKOUT, MD_LOCKDOWN, MD_NEWPIN
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [7:0]     r_digits [PIN_LEN];
    logic [7:0]     n_digits [PIN_LEN];
    logic [7:0]     r_pin    [PIN_LEN];
    logic [7:0]     n_pin    [PIN_LEN];
    logic [7:0]     pin_init [PIN_LEN];
    logic [PW-1:0]  r_pos, n_pos;
    logic [3:0]     r_wrong, n_wrong;
    logic [3:0]     r_rounds, n_rounds;
    logic [11:0]    r_count, n_count;
    logic [5:0]     r_ldsec, n_ldsec;
    logic [15:0]    r_ldmin, n_ldmin;

    logic [3:0]     status;
    logic           match;
    logic [3:0]     wrong_inc;
    logic [3:0]     rounds_inc;
    logic [11:0]    count_dec;
    logic [5:0]     ldsec_inc;
    logic [PW-1:0]  pos_inc;
    logic [PW-1:0]  pos_dec;

    for (genvar g = 0; g < PIN_LEN; g++) begin : g_init
        localparam logic [7:0] INIT = 8'h30 + 8'((g + 1) % 10);
        assign pin_init[g] = INIT;
    end

    always_comb begin
        match = (r_pos == POS_FULL);
        for (int k = 0; k < PIN_LEN; k++) begin
            if (r_digits[k] != r_pin[k]) match = 1'b0;
        end
    end

    assign wrong_inc  = (r_wrong < CNT_MAX) ? r_wrong + 4'd1 : r_wrong;
    assign rounds_inc = (r_rounds < CNT_MAX) ? r_rounds + 4'd1 : r_rounds;
    assign count_dec  = (r_count != 12'd0) ? r_count - 12'd1 : 12'd0;
    assign ldsec_inc  = r_ldsec + 6'd1;
    assign pos_inc    = r_pos + PW'(1);
    assign pos_dec    = r_pos - PW'(1);

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_pin    = r_pin;
        n_pos    = r_pos;
        n_wrong  = r_wrong;
        n_rounds = r_rounds;
        n_count  = r_count;
        n_ldsec  = r_ldsec;
        n_ldmin  = r_ldmin;
        status   = ST_IGNORED;
        if (!i_item.cmd) begin
            unique case (r_mode)
                MD_NEWPIN: begin
                    if (r_pos < POS_FULL) n_pin[r_pos[IW-1:0]] = i_item.key_code;
                    if (pos_inc >= POS_FULL) begin
                        for (int k = 0; k < PIN_LEN; k++) n_digits[k] = 8'd0;
                        n_pos    = '0;
                        n_wrong  = 4'd0;
                        n_rounds = 4'd0;
                        n_mode   = MD_ENTER;
                        status   = ST_STORED;
                    end else begin
                        n_pos  = pos_inc;
                        status = ST_DIGIT;
                    end
                end
                MD_WAITD: begin
                    if (i_item.key_code == KEY_SUBMIT) begin
                        for (int k = 0; k < PIN_LEN; k++) n_digits[k] = 8'd0;
                        n_pos    = '0;
                        n_wrong  = 4'd0;
                        n_rounds = 4'd0;
                        n_mode   = MD_ENTER;
                        status   = ST_ENTERING;
                    end
                end
                MD_OPEN, MD_LOCKOUT, MD_LOCKDOWN: status = ST_IGNORED;
                default: begin
                    n_mode = MD_ENTER;
                    if (i_item.key_code == KEY_SUBMIT) begin
                        if (i_item.reset_switch) begin
                            for (int k = 0; k < PIN_LEN; k++) n_digits[k] = 8'd0;
                            n_pos  = '0;
                            n_mode = MD_NEWPIN;
                            status = ST_NEWPIN;
                        end else if (match) begin
                            n_mode  = MD_OPEN;
                            n_count = 12'(i_cfg.unlock_seconds);
                            status  = ST_GRANTED;
                        end else begin
                            n_wrong = wrong_inc;
                            for (int k = 0; k < PIN_LEN; k++) n_digits[k] = 8'd0;
                            n_pos = '0;
                            if (wrong_inc < i_cfg.attempts_before_lockout) begin
                                status = ST_WRONG;
                            end else begin
                                n_rounds = rounds_inc;
                                if (rounds_inc < i_cfg.lockouts_before_lockdown) begin
                                    n_mode  = MD_LOCKOUT;
                                    n_count = 12'(i_cfg.lockout_step_seconds) *
                                              12'(rounds_inc);
                                    status  = ST_LOCKOUT;
                                end else begin
                                    n_mode  = MD_LOCKDOWN;
                                    n_ldsec = 6'd0;
                                    n_ldmin = 16'd0;
                                    status  = ST_LOCKDOWN;
                                end
                            end
                        end
                    end else if (i_item.key_code == KEY_BACK) begin
                        if (r_pos != '0) begin
                            n_pos = pos_dec;
                            n_digits[pos_dec[IW-1:0]] = 8'd0;
                            status = ST_ENTERING;
                        end
                    end else if (r_pos < POS_FULL) begin
                        n_digits[r_pos[IW-1:0]] = i_item.key_code;
                        n_pos  = pos_inc;
                        status = ST_DIGIT;
                    end
                end
            endcase
        end else begin
            unique case (r_mode)
                MD_OPEN: begin
                    n_count = count_dec;
                    if (count_dec == 12'd0) n_mode = MD_WAITD;
                    status = ST_COUNTING;
                end
                MD_LOCKOUT: begin
                    n_count = count_dec;
                    if (count_dec == 12'd0) begin
                        n_wrong = 4'd0;
                        for (int k = 0; k < PIN_LEN; k++) n_digits[k] = 8'd0;
                        n_pos  = '0;
                        n_mode = MD_ENTER;
                        status = ST_ENTERING;
                    end else begin
                        status = ST_LOCKOUT;
                    end
                end
                MD_LOCKDOWN: begin
                    if (i_item.reset_switch) begin
                        for (int k = 0; k < PIN_LEN; k++) n_digits[k] = 8'd0;
                        n_pos    = '0;
                        n_wrong  = 4'd0;
                        n_rounds = 4'd0;
                        n_ldsec  = 6'd0;
                        n_ldmin  = 16'd0;
                        n_mode   = MD_ENTER;
                        status   = ST_ENTERING;
                    end else begin
                        if (ldsec_inc >= SECS_PER_MIN) begin
                            n_ldsec = 6'd0;
                            if (r_ldmin < MIN_MAX) n_ldmin = r_ldmin + 16'd1;
                        end else begin
                            n_ldsec = ldsec_inc;
                        end
                        status = ST_LOCKDOWN;
                    end
                end
                default: status = ST_IGNORED;
            endcase
        end
    end

    always_comb begin
        o_result.status         = status;
        o_result.door_open      = (n_mode == MD_OPEN);
        o_result.alarm          = (n_mode == MD_LOCKOUT) || (n_mode == MD_LOCKDOWN);
        o_result.digits_entered = 5'(n_pos);
        if (n_mode == MD_LOCKOUT) begin
            o_result.seconds_value = n_count;
        end else if (n_mode == MD_LOCKDOWN) begin
            o_result.seconds_value = 12'(n_ldsec);
        end else begin
            o_result.seconds_value = 12'd0;
        end
        o_result.minutes_value  = (n_mode == MD_LOCKDOWN) ? n_ldmin : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MD_ENTER;
            r_pos    <= '0;
            r_wrong  <= 4'd0;
            r_rounds <= 4'd0;
            r_count  <= 12'd0;
            r_ldsec  <= 6'd0;
            r_ldmin  <= 16'd0;
            for (int k = 0; k < PIN_LEN; k++) begin
                r_digits[k] <= 8'd0;
                r_pin[k]    <= pin_init[k];
            end
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_wrong  <= n_wrong;
            r_rounds <= n_rounds;
            r_count  <= n_count;
            r_ldsec  <= n_ldsec;
            r_ldmin  <= n_ldmin;
            r_digits <= n_digits;
            r_pin    <= n_pin;
        end
    end

endmodule

// ===== hw/rtl/keypad_pin_lock_controller_top.sv =====
// Keypad PIN lock controller: input register, lock core, result register.
// Depends on kplc_pkg, kplc_cfg_regs and kplc_core.
//
// Usage:
//   The slave stream carries events: a key press (tuser = 0) with its ASCII
//   code, or a one-second tick (tuser = 1), plus the level of the PIN-reset
//   switch. Every event gives exactly one result item on the master stream:
//   a status code, door and alarm drives, the entry count and the lockout
//   or lockdown time values.
//   An accepted event waits in the input register; its result is loaded
//   into the result register when that is free. Throughput is one event
//   per cycle while the receiver takes results, set by the combinational
//   next-state logic of the lock core between input and result registers.
//   When the receiver stalls, the result holds and one more event waits in
//   the input register; s_axis_tready then drops until the result is taken.
//   The configuration channel is always ready and takes a write per cycle;
//   write it only while no event is in flight.
//   Reset (synchronous, active low) empties both registers, restores the
//   PIN "12345", clears all counters and loads the default thresholds.
module keypad_pin_lock_controller_top #(
    parameter int PIN_LEN = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // key_code[7:0], reset_switch[8], zero[15:9]
    input  logic [0:0]  s_axis_tuser,  // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[3:0], door_open[4], alarm[5],
                                       // digits_entered[10:6], seconds_value[22:11],
                                       // minutes_value[38:23], zero[39]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import kplc_pkg::*;

    t_cfg     cfg;
    t_result  result;
    t_in_item r_in_item;
    logic     r_in_valid;
    t_result  r_out;
    logic     r_out_valid;
    logic     advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    kplc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kplc_core #(
        .PIN_LEN (PIN_LEN)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.cmd          <= s_axis_tuser[0];
            r_in_item.key_code     <= s_axis_tdata[7:0];
            r_in_item.reset_switch <= s_axis_tdata[8];
        end
        if (advance) begin
            r_out <= result;
        end
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_door_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.door_open) |->
            (r_out.status == ST_GRANTED || r_out.status == ST_COUNTING ||
             r_out.status == ST_IGNORED))
        else $error("door open with unexpected status");

    a_alarm_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.alarm) |->
            (r_out.status == ST_LOCKOUT || r_out.status == ST_LOCKDOWN ||
             r_out.status == ST_IGNORED))
        else $error("alarm with unexpected status");

    a_time_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.seconds_value != 12'd0 || r_out.minutes_value != 16'd0))
            |-> (r_out.alarm && !r_out.door_open))
        else $error("time value shown outside lockout or lockdown");

endmodule
